// ===== design/cst_pkg.sv =====
// cst_pkg: shared types and constants for the character stream tokenizer
// no dependencies; used by the interfaces, the classifier and the top level

package cst_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned KindWidth = 4;

   typedef logic [CharWidth-1:0] char_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_IDENT = 3'd1,
      ST_NUM   = 3'd2,
      ST_COLON = 3'd3,
      ST_DASH  = 3'd4
   } scan_state_type;

   typedef enum logic [KindWidth-1:0] {
      K_IDENT  = 4'd0,
      K_NUMBER = 4'd1,
      K_SCOPE  = 4'd2,
      K_DOT    = 4'd3,
      K_COMMA  = 4'd4,
      K_SEMI   = 4'd5,
      K_ARROW  = 4'd6,
      K_OPENP  = 4'd7,
      K_CLOSEP = 4'd8,
      K_OPENB  = 4'd9,
      K_CLOSEB = 4'd10
   } token_kind_type;

   // character codes
   localparam char_type ChColon  = 8'h3A;
   localparam char_type ChDash   = 8'h2D;
   localparam char_type ChGt     = 8'h3E;
   localparam char_type ChUscore = 8'h5F;
   localparam char_type ChZero   = 8'h30;
   localparam char_type ChNine   = 8'h39;
   localparam char_type ChUpA    = 8'h41;
   localparam char_type ChUpZ    = 8'h5A;
   localparam char_type ChLowA   = 8'h61;
   localparam char_type ChLowZ   = 8'h7A;
   localparam char_type ChDot    = 8'h2E;
   localparam char_type ChComma  = 8'h2C;
   localparam char_type ChSemi   = 8'h3B;
   localparam char_type ChOpenP  = 8'h28;
   localparam char_type ChCloseP = 8'h29;
   localparam char_type ChOpenB  = 8'h7B;
   localparam char_type ChCloseB = 8'h7D;

   // one result item
   typedef struct packed {
      token_kind_type kind;
      char_type       value;
      logic           start;
   } token_type;

   // classifier decision for one character
   typedef struct packed {
      logic           emit;
      token_type      token;
      scan_state_type next_state;
   } decision_type;

   function automatic logic is_alpha(input char_type c);
      is_alpha = (c >= ChUpA && c <= ChUpZ) || (c >= ChLowA && c <= ChLowZ) ||
                 (c == ChUscore);
   endfunction

   function automatic logic is_digit(input char_type c);
      is_digit = (c >= ChZero) && (c <= ChNine);
   endfunction

endpackage

// ===== design/cst_req_if.sv =====
// cst_req_if: valid/ready channel carrying one source character per item
// depends on cst_pkg

interface cst_req_if;
   import cst_pkg::*;

   logic     valid;
   logic     ready;
   char_type char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// ===== design/cst_rsp_if.sv =====
// cst_rsp_if: valid/ready channel carrying one token result per item
// depends on cst_pkg

interface cst_rsp_if;
   import cst_pkg::*;

   logic           valid;
   logic           ready;
   token_kind_type token_kind;
   char_type       char_value;
   logic           token_start;

   modport source (output valid, output token_kind, output char_value,
                   output token_start, input ready);
   modport sink   (input valid, input token_kind, input char_value,
                   input token_start, output ready);
endinterface

// ===== design/cst_classify.sv =====
// cst_classify: combinational scanner step, current state and character in,
// optional token and next state out; depends on cst_pkg

module cst_classify (
   input  cst_pkg::scan_state_type state,
   input  cst_pkg::char_type       char_code,
   output cst_pkg::decision_type   decision
);
   import cst_pkg::*;

   logic alpha;
   logic digit;

   assign alpha = is_alpha(char_code);
   assign digit = is_digit(char_code);

   always_comb begin
      decision             = '0;
      decision.next_state  = ST_IDLE;
      decision.token.value = char_code;
      decision.token.kind  = K_IDENT;
      decision.token.start = 1'b1;

      if ((state == ST_COLON) && (char_code == ChColon)) begin
         decision.emit       = 1'b1;
         decision.token.kind = K_SCOPE;
      end else if ((state == ST_DASH) && (char_code == ChGt)) begin
         decision.emit       = 1'b1;
         decision.token.kind = K_ARROW;
      end else if (alpha) begin
         decision.emit        = 1'b1;
         decision.next_state  = ST_IDENT;
         decision.token.start = (state != ST_IDENT);
      end else if (digit) begin
         decision.emit = 1'b1;
         if (state == ST_IDENT) begin
            // digit keeps the identifier going
            decision.next_state  = ST_IDENT;
            decision.token.start = 1'b0;
         end else begin
            decision.next_state  = ST_NUM;
            decision.token.kind  = K_NUMBER;
            decision.token.start = (state != ST_NUM);
         end
      end else begin
         case (char_code)
            ChColon:  decision.next_state = ST_COLON;
            ChDash:   decision.next_state = ST_DASH;
            ChDot: begin
               decision.emit = 1'b1; decision.token.kind = K_DOT;
            end
            ChComma: begin
               decision.emit = 1'b1; decision.token.kind = K_COMMA;
            end
            ChSemi: begin
               decision.emit = 1'b1; decision.token.kind = K_SEMI;
            end
            ChOpenP: begin
               decision.emit = 1'b1; decision.token.kind = K_OPENP;
            end
            ChCloseP: begin
               decision.emit = 1'b1; decision.token.kind = K_CLOSEP;
            end
            ChOpenB: begin
               decision.emit = 1'b1; decision.token.kind = K_OPENB;
            end
            ChCloseB: begin
               decision.emit = 1'b1; decision.token.kind = K_CLOSEB;
            end
            default:  decision.emit = 1'b0;
         endcase
      end
   end

endmodule

// ===== design/char_stream_tokenizer.sv =====
// char_stream_tokenizer: each accepted character passes the input register, then the
// result register on its way to its token; throughput one character per cycle
// while the result side takes items; characters that make no token only update state
// reset (synchronous, active high) empties both registers and returns the scanner to idle
// depends on cst_pkg, cst_req_if, cst_rsp_if and cst_classify

module char_stream_tokenizer (
   input logic     clock,
   input logic     reset,
   cst_req_if.sink   req_chan,
   cst_rsp_if.source rsp_chan
);
   import cst_pkg::*;

   // input register stage
   logic           in_valid_ff, in_valid_in;
   char_type       in_char_ff,  in_char_in;

   // scanner state, updated as each character leaves the input register
   scan_state_type state_ff, state_in;

   // result register
   logic           out_valid_ff, out_valid_in;
   token_type      out_token_ff, out_token_in;

   decision_type   decision;
   logic           advance;

   // the input register moves on whenever the result register is free
   // or is being emptied in this cycle
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   cst_classify u_classify (
      .state     (state_ff),
      .char_code (in_char_ff),
      .decision  (decision)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_char_in   = in_char_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_token_in = out_token_ff;

      // result register drains
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      // character leaves the input register
      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = decision.next_state;
         if (decision.emit) begin
            out_valid_in = 1'b1;
            out_token_in = decision.token;
         end
      end

      // new character arrives
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_chan.char_code;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_char_ff   <= in_char_in;
      out_token_ff <= out_token_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.token_kind  = out_token_ff.kind;
   assign rsp_chan.char_value  = out_token_ff.value;
   assign rsp_chan.token_start = out_token_ff.start;

   // a stalled character waits in the input register unchanged
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff))
      else $error("input register lost a stalled character");

   // pair and single tokens always begin a token
   a_punct_start: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_token_ff.kind != K_IDENT) && (out_token_ff.kind != K_NUMBER)
      |-> out_token_ff.start)
      else $error("punctuation token without start flag");

   // a continuation character is only ever part of an identifier or number
   a_cont_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_token_ff.start
      |-> (out_token_ff.kind == K_IDENT) || (out_token_ff.kind == K_NUMBER))
      else $error("continuation flag on a non-run token");

   // a colon that does not close a pair leaves the scanner pending on it
   a_colon_pend: assert property (@(posedge clock) disable iff (reset)
      advance && (in_char_ff == ChColon) && (state_ff != ST_COLON)
      |=> state_ff == ST_COLON)
      else $error("lone colon not held pending");

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for the char_stream_tokenizer, driving text one byte at a time
// keeps its own scanner model and a queue of expected tokens, compares every result item
// depends on cst_pkg, cst_req_if, cst_rsp_if and the char_stream_tokenizer design

module tb;
   import cst_pkg::*;

   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned DrainCycles = 6;

   logic clock = 1'b0;
   logic reset;

   // free-running clock, period 20
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cst_req_if req_bus ();
   cst_rsp_if rsp_bus ();

   char_stream_tokenizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // scanner model state and the tokens still owed by the block
   scan_state_type scanner_state;
   token_type      expected_tokens[$];
   int unsigned    mismatch_count;
   int unsigned    token_char_count;   // accepted chars that produce a token
   int unsigned    cycle_count;

   // idling controls, shared with the sender and receiver
   bit          gaps_on;
   bit          stalls_on;
   int unsigned rsp_hold_left;
   int unsigned stall_left;

   // ---------------------------------------------------------------------------
   // scanner model: advances the state for one char, returns 1 when a token comes out
   // ---------------------------------------------------------------------------
   function automatic logic predict_token(input char_type c, output token_type tok);
      scan_state_type prior;
      logic           word_char;
      logic           digit_char;
      logic           produced;
      prior      = scanner_state;
      word_char  = (c >= ChUpA && c <= ChUpZ) || (c >= ChLowA && c <= ChLowZ) ||
                   (c == ChUscore);
      digit_char = (c >= ChZero && c <= ChNine);
      tok.kind   = K_IDENT;
      tok.value  = c;
      tok.start  = 1'b1;

      // a pending colon or dash that completes its pair
      if (prior == ST_COLON && c == ChColon) begin
         scanner_state = ST_IDLE;
         tok.kind      = K_SCOPE;
         return 1'b1;
      end
      if (prior == ST_DASH && c == ChGt) begin
         scanner_state = ST_IDLE;
         tok.kind      = K_ARROW;
         return 1'b1;
      end

      // letters always give an identifier char; a new token unless one is running
      if (word_char) begin
         tok.start     = (prior != ST_IDENT);
         scanner_state = ST_IDENT;
         return 1'b1;
      end

      // digit after an identifier stays in the identifier
      if (digit_char) begin
         if (prior == ST_IDENT) begin
            tok.start = 1'b0;
            return 1'b1;
         end
         tok.kind      = K_NUMBER;
         tok.start     = (prior != ST_NUM);
         scanner_state = ST_NUM;
         return 1'b1;
      end

      // anything else ends a run or drops the pending char, then is seen from idle
      scanner_state = ST_IDLE;
      produced      = 1'b1;
      case (c)
         ChColon: begin
            scanner_state = ST_COLON;
            produced      = 1'b0;
         end
         ChDash: begin
            scanner_state = ST_DASH;
            produced      = 1'b0;
         end
         ChDot:    tok.kind = K_DOT;
         ChComma:  tok.kind = K_COMMA;
         ChSemi:   tok.kind = K_SEMI;
         ChOpenP:  tok.kind = K_OPENP;
         ChCloseP: tok.kind = K_CLOSEP;
         ChOpenB:  tok.kind = K_OPENB;
         ChCloseB: tok.kind = K_CLOSEB;
         default:  produced = 1'b0;
      endcase
      return produced;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------------
   // input monitor: every accepted char runs through the scanner model
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      token_type tok;
      if (!reset && req_bus.valid && req_bus.ready) begin
         if (predict_token(req_bus.char_code, tok)) begin
            expected_tokens = {expected_tokens, tok};
            token_char_count++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result checker: each accepted token against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected token kind %0d value %02h start %0b",
                                      rsp_bus.token_kind, rsp_bus.char_value,
                                      rsp_bus.token_start));
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_bus.token_kind !== want.kind)
               report_mismatch($sformatf("token_kind got %0d want %s",
                                         rsp_bus.token_kind, want.kind.name()));
            if (rsp_bus.char_value !== want.value)
               report_mismatch($sformatf("char_value got %02h want %02h",
                                         rsp_bus.char_value, want.value));
            if (rsp_bus.token_start !== want.start)
               report_mismatch($sformatf("token_start got %0b want %0b for char %02h",
                                         rsp_bus.token_start, want.start, want.value));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: long hold-offs first, then random stall bursts of ready-low cycles
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d tokens outstanding",
                  cycle_count, expected_tokens.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // sender: one char per call, returns at the edge where it is taken;
   // valid stays high, so back-to-back calls with gaps off stream without a bubble
   // ---------------------------------------------------------------------------
   task automatic send_char(input char_type c);
      int unsigned gap;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.char_code <= c;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(char_type'(s[i]));
   endtask

   // stop offering and let every owed token come out, plus the pipeline tail
   task automatic wait_for_tokens();
      req_bus.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic char_type pick_word_char();
      case ($urandom_range(0, 2))
         0:       return char_type'(ChUpA + $urandom_range(0, 25));
         1:       return char_type'(ChLowA + $urandom_range(0, 25));
         default: return ChUscore;
      endcase
   endfunction

   function automatic char_type pick_digit();
      return char_type'(ChZero + $urandom_range(0, 9));
   endfunction

   // one well-formed lexeme with random content, or a separator, stray or noise byte
   task automatic send_random_lexeme();
      char_type    singles[7];
      int unsigned len;
      logic [2:0]  single_sel;
      singles = '{ChDot, ChComma, ChSemi, ChOpenP, ChCloseP, ChOpenB, ChCloseB};
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            len = $urandom_range(1, 8);
            send_char(pick_word_char());
            for (int i = 1; i < len; i++)
               send_char($urandom_range(0, 2) == 0 ? pick_digit() : pick_word_char());
         end
         3, 4: begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) send_char(pick_digit());
         end
         5, 6: begin
            if ($urandom_range(0, 1)) begin
               send_char(ChColon);
               send_char(ChColon);
            end else begin
               send_char(ChDash);
               send_char(ChGt);
            end
         end
         7, 8: begin
            single_sel = 3'($urandom_range(0, 6));
            send_char(singles[single_sel]);
         end
         9:       send_char($urandom_range(0, 1) ? char_type'(8'h20) : char_type'(8'h0A));
         10:      send_char($urandom_range(0, 1) ? ChColon : ChDash);
         default: send_char(char_type'($urandom_range(0, 255)));
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // byte extremes and chars just outside the letter ranges give nothing
   task automatic test_extremes();
      send_char(8'h00);
      send_char(8'hFF);
      send_text("@[");
   endtask

   // identifier with trailing digit, then a number that a letter cuts off
   task automatic test_word_runs();
      send_text("_aZ9 9x0");
      send_char(8'h0A);
   endtask

   // triple colon, unpaired colon and dash, arrow, dash dropped by a letter
   task automatic test_pairs();
      send_text(":::-->-a");
   endtask

   task automatic test_singles();
      send_text(".,;(){}");
      wait_for_tokens();
   endtask

   // random text until the given number of token chars has been accepted
   task automatic test_random_text(input int unsigned count);
      int unsigned target;
      target = token_char_count + count;
      while (token_char_count < target) send_random_lexeme();
   endtask

   // receiver holds off for a long stretch while chars keep coming, so the
   // block fills and has to stall its input
   task automatic test_output_hold();
      bit saved_gaps;
      saved_gaps    = gaps_on;
      gaps_on       = 1'b0;
      rsp_hold_left = 48;
      for (int i = 0; i < 30; i++)
         send_char($urandom_range(0, 1) ? pick_word_char() : pick_digit());
      gaps_on = saved_gaps;
      wait_for_tokens();
   endtask

   // sender pauses mid-stream until the block has delivered everything
   task automatic test_pause_drain();
      for (int i = 0; i < 15; i++) send_random_lexeme();
      wait_for_tokens();
      for (int i = 0; i < 15; i++) send_random_lexeme();
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.char_code = '0;
      rsp_bus.ready     = 1'b0;
      scanner_state     = ST_IDLE;
      mismatch_count    = 0;
      token_char_count  = 0;
      cycle_count       = 0;
      rsp_hold_left     = 0;
      stall_left        = 0;
      gaps_on           = 1'b1;
      stalls_on         = 1'b1;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_word_runs();
      test_pairs();
      test_singles();
      test_random_text(250);
      test_output_hold();
      test_pause_drain();
      test_random_text(150);

      // last stretch streams with no idling on either side
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      test_random_text(150);
      wait_for_tokens();

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
